>>> design/dteq_pkg.sv
// ----------------------------------------------------------------------------
// dteq_pkg
// Shared types and constants of the deadline timer event queue.
// ----------------------------------------------------------------------------
package dteq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_SCHED  = 2'd1;
  localparam logic [1:0] MODE_CANCEL = 2'd2;

  localparam logic [2:0] ST_FIRED     = 3'd0;
  localparam logic [2:0] ST_ACCEPTED  = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_PAST      = 3'd3;
  localparam logic [2:0] ST_CANCELLED = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  event_id;
    logic [31:0] deadline;
  } req_t;

  typedef struct packed {
    logic [7:0] event_id_res;
    logic [2:0] status;
    logic       last;
  } res_t;

endpackage

>>> design/dteq_req_if.sv
// ----------------------------------------------------------------------------
// dteq_req_if
// Request channel carrying mode, event id and deadline.
// ----------------------------------------------------------------------------
interface dteq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  event_id;
  logic [31:0] deadline;

  modport source (output valid, mode, event_id, deadline, input ready);
  modport sink   (input valid, mode, event_id, deadline, output ready);
endinterface

>>> design/dteq_res_if.sv
// ----------------------------------------------------------------------------
// dteq_res_if
// Result channel carrying event id, status and last flag.
// ----------------------------------------------------------------------------
interface dteq_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] event_id_res;
  logic [2:0] status;
  logic       last;

  modport source (output valid, event_id_res, status, last, input ready);
  modport sink   (input valid, event_id_res, status, last, output ready);
endinterface

>>> design/dteq_front.sv
// ----------------------------------------------------------------------------
// dteq_front
// Accepts requests, masks the id, drops unused modes and queues the rest
// in a two-entry FIFO toward the back end.
// ----------------------------------------------------------------------------
module dteq_front (
  input  logic           clk,
  input  logic           rst,
  dteq_req_if.sink       req,
  output logic           q_valid,
  input  logic           q_ready,
  output dteq_pkg::req_t q_data
);
  import dteq_pkg::*;

  req_t       fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  req_t       item;

  // Classify: keep only the low ID_BITS of the id.
  always_comb begin
    item.mode     = req.mode;
    item.event_id = req.event_id & 8'((1 << ID_BITS) - 1);
    item.deadline = req.deadline;
  end

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready &&
                     (req.mode == MODE_TICK || req.mode == MODE_SCHED ||
                      req.mode == MODE_CANCEL);
  assign pop       = q_valid && q_ready;
  assign q_valid   = (count != 2'd0);
  assign q_data    = fifo[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= item;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("request queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
`endif
endmodule

>>> design/dteq_back.sv
// ----------------------------------------------------------------------------
// dteq_back
// Sorted shifting slot chain with tick counter. Carries out one request at
// a time and issues results through an output register.
// ----------------------------------------------------------------------------
module dteq_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  dteq_pkg::req_t q_data,
  dteq_res_if.source     res
);
  import dteq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIRE = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]        state;
  logic [31:0]       tick_count;
  logic [31:0]       slot_deadline [QUEUE_DEPTH];
  logic [7:0]        slot_id       [QUEUE_DEPTH];
  logic [CNT_W-1:0]  used;
  logic [RCNT_W-1:0] fired;
  res_t              out_reg;
  logic              out_valid;
  logic              out_free;

  logic [QUEUE_DEPTH-1:0] le_vec;
  logic [QUEUE_DEPTH-1:0] id_hit;
  logic [QUEUE_DEPTH-1:0] first_hit;
  logic [QUEUE_DEPTH-1:0] after_hit;
  logic                   any_hit;
  logic                   head_due;
  logic                   more_due;
  logic                   accept;

  assign out_free = !out_valid || res.ready;
  assign q_ready  = (state == S_IDLE) && out_free;
  assign accept   = q_valid && q_ready;

  // Per-slot compares for insertion point and cancel match.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      le_vec[i] = (CNT_W'(i) < used) && (slot_deadline[i] <= q_data.deadline);
      id_hit[i] = (CNT_W'(i) < used) && (slot_id[i] == q_data.event_id);
    end
    first_hit = id_hit & (~id_hit + QUEUE_DEPTH'(1));
    after_hit = ~((first_hit - QUEUE_DEPTH'(1)) | first_hit);
    any_hit   = |id_hit;
  end

  assign head_due = (used != '0) && (slot_deadline[0] <= tick_count);
  assign more_due = (used > CNT_W'(1)) && (slot_deadline[1] <= tick_count);

  // Control sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tick_count <= '0;
      used       <= '0;
      fired      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (res.valid && res.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (q_data.mode)
              MODE_TICK: begin
                tick_count <= tick_count + 32'd1;
                fired      <= '0;
                state      <= S_FIRE;
              end
              MODE_SCHED: begin
                out_valid <= 1'b1;
                if (q_data.deadline > tick_count && used != CNT_W'(QUEUE_DEPTH)) begin
                  used <= used + CNT_W'(1);
                end
              end
              MODE_CANCEL: begin
                out_valid <= 1'b1;
                if (any_hit) used <= used - CNT_W'(1);
              end
              default: ;
            endcase
          end
        end
        S_FIRE: begin
          if (out_free) begin
            if (head_due) begin
              out_valid <= 1'b1;
              used      <= used - CNT_W'(1);
              fired     <= fired + RCNT_W'(1);
              if (!more_due || fired == RCNT_W'(MAX_RESULTS - 1)) state <= S_OUT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Slot chain and result payload.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && q_data.mode == MODE_SCHED) begin
      out_reg.event_id_res <= q_data.event_id;
      out_reg.last         <= 1'b1;
      if (q_data.deadline <= tick_count) begin
        out_reg.status <= ST_PAST;
      end else if (used == CNT_W'(QUEUE_DEPTH)) begin
        out_reg.status <= ST_FULL;
      end else begin
        out_reg.status <= ST_ACCEPTED;
        if (!le_vec[0]) begin
          slot_deadline[0] <= q_data.deadline;
          slot_id[0]       <= q_data.event_id;
        end
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
          if (!le_vec[i]) begin
            if (le_vec[i-1]) begin
              slot_deadline[i] <= q_data.deadline;
              slot_id[i]       <= q_data.event_id;
            end else begin
              slot_deadline[i] <= slot_deadline[i-1];
              slot_id[i]       <= slot_id[i-1];
            end
          end
        end
      end
    end else if (state == S_IDLE && accept && q_data.mode == MODE_CANCEL) begin
      out_reg.event_id_res <= q_data.event_id;
      out_reg.last         <= 1'b1;
      out_reg.status       <= any_hit ? ST_CANCELLED : ST_NOT_FOUND;
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        if (after_hit[i] || first_hit[i]) begin
          slot_deadline[i] <= slot_deadline[i+1];
          slot_id[i]       <= slot_id[i+1];
        end
      end
    end else if (state == S_FIRE && out_free && head_due) begin
      out_reg.event_id_res <= slot_id[0];
      out_reg.status       <= ST_FIRED;
      out_reg.last         <= !more_due || fired == RCNT_W'(MAX_RESULTS - 1);
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        slot_deadline[i] <= slot_deadline[i+1];
        slot_id[i]       <= slot_id[i+1];
      end
    end
  end

  assign res.valid        = out_valid;
  assign res.event_id_res = out_reg.event_id_res;
  assign res.status       = out_reg.status;
  assign res.last         = out_reg.last;

`ifndef NO_ASSERTIONS
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(QUEUE_DEPTH)) else $error("slot count out of range");
  a_fire_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_FIRE |-> fired < RCNT_W'(MAX_RESULTS)) else $error("too many fires");
  a_one_hit: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> $onehot0(first_hit)) else $error("cancel match not unique");
  a_tick_step: assert property (@(posedge clk) disable iff (rst)
    state == S_FIRE |=> $stable(tick_count)) else $error("tick moved while firing");
`endif
endmodule

>>> design/deadline_timer_event_queue_top.sv
// A schedule or cancel result is registered in the output register when the back
// end accepts it; fired events of a tick are registered there in the fire state.
// Throughput: one schedule or cancel per cycle while the receiver is ready and
// no tick is firing; a tick holds the slot chain while up to 16 events fire.
// A two-entry request queue decouples acceptance from the slot chain.
// Synchronous active-high reset: tick count zero, table empty, queue empty.
// ----------------------------------------------------------------------------
// deadline_timer_event_queue_top
// Top level joining the request front end and the sorted slot back end.
// ----------------------------------------------------------------------------
module deadline_timer_event_queue_top (
  input  logic       clk,
  input  logic       rst,
  dteq_req_if.sink   req,
  dteq_res_if.source res
);
  import dteq_pkg::*;

  logic q_valid;
  logic q_ready;
  req_t q_data;

  dteq_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data)
  );

  dteq_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .res     (res)
  );
endmodule

>>> dv/tb_deadline_timer_event_queue_top.sv
// ----------------------------------------------------------------------------
// tb_deadline_timer_event_queue_top
// Self-checking bench for the deadline timer event queue. Requests are driven
// on the request channel, and a behavioral queue model predicts every result.
// A monitor compares each result field by field with the oldest prediction.
// The run has a directed part, then random phases under several idle and
// stall patterns.
// ----------------------------------------------------------------------------
module tb_deadline_timer_event_queue_top;
  import dteq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 40;

  logic clk;
  logic rst;

  dteq_req_if req_if ();
  dteq_res_if res_if ();

  deadline_timer_event_queue_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .res (res_if.source)
  );

  // Behavioral copy of the sorted event table.
  logic [31:0] mdl_tick;
  logic [31:0] mdl_deadline [QUEUE_DEPTH];
  logic [7:0]  mdl_id       [QUEUE_DEPTH];
  int          mdl_used;

  // Results still owed by the block, oldest first.
  res_t        pending_results [$];

  int send_idle_pct;
  int recv_stall_pct;
  int error_count;
  int request_count;
  int result_count;
  int fired_count;
  int quiet_cycles;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Queue a single expected result.
  function automatic void push_result(logic [7:0] id, logic [2:0] st, logic lst);
    res_t r;
    r.event_id_res = id;
    r.status       = st;
    r.last         = lst;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Update the table model for one accepted request and queue its results.
  function automatic void predict_request(logic [1:0] mode, logic [7:0] id,
                                          logic [31:0] dl);
    int pos;
    int fired;
    bit found;
    fired = 0;
    found = 1'b0;
    pos   = 0;
    case (mode)
      MODE_TICK: begin
        mdl_tick = mdl_tick + 32'd1;
        while (fired < MAX_RESULTS && mdl_used > 0 && mdl_deadline[0] <= mdl_tick) begin
          push_result(mdl_id[0], ST_FIRED, 1'b0);
          for (int i = 0; i + 1 < mdl_used; i++) begin
            mdl_deadline[i] = mdl_deadline[i + 1];
            mdl_id[i]       = mdl_id[i + 1];
          end
          mdl_used--;
          fired++;
        end
        if (fired > 0) begin
          pending_results[pending_results.size() - 1].last = 1'b1;
        end
        fired_count += fired;
      end
      MODE_SCHED: begin
        if (dl <= mdl_tick) begin
          push_result(id, ST_PAST, 1'b1);
        end else if (mdl_used >= QUEUE_DEPTH) begin
          push_result(id, ST_FULL, 1'b1);
        end else begin
          while (pos < mdl_used && mdl_deadline[pos] <= dl) pos++;
          for (int i = mdl_used; i > pos; i--) begin
            mdl_deadline[i] = mdl_deadline[i - 1];
            mdl_id[i]       = mdl_id[i - 1];
          end
          mdl_deadline[pos] = dl;
          mdl_id[pos]       = id;
          mdl_used++;
          push_result(id, ST_ACCEPTED, 1'b1);
        end
      end
      MODE_CANCEL: begin
        for (int i = 0; i < mdl_used && !found; i++) begin
          if (mdl_id[i] == id) begin
            for (int j = i; j + 1 < mdl_used; j++) begin
              mdl_deadline[j] = mdl_deadline[j + 1];
              mdl_id[j]       = mdl_id[j + 1];
            end
            mdl_used--;
            found = 1'b1;
          end
        end
        push_result(id, found ? ST_CANCELLED : ST_NOT_FOUND, 1'b1);
      end
      default: begin
        // Unused mode: no effect.
      end
    endcase
  endfunction

  // Send one request and update the model when it is accepted.
  task automatic send_request(logic [1:0] mode, logic [7:0] id, logic [31:0] dl);
    bit lowered;
    lowered = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      if (!lowered) req_if.valid <= 1'b0;
      lowered = 1'b1;
      @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.mode     <= mode;
    req_if.event_id <= id;
    req_if.deadline <= dl;
    do @(posedge clk); while (!req_if.ready);
    predict_request(mode, id, dl);
    request_count++;
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Extremes, the past and full cases, equal deadlines and a full burst.
  task automatic test_directed();
    send_request(MODE_SCHED, 8'h00, 32'h0000_0000);
    send_request(MODE_SCHED, 8'hFF, 32'hFFFF_FFFF);
    send_request(MODE_CANCEL, 8'h11, 32'h0);
    send_request(MODE_CANCEL, 8'hFF, 32'hFFFF_FFFF);
    send_request(2'd3, 8'hA5, 32'h5A5A_5A5A);
    // Sixteen entries with one deadline fill the table in insertion order.
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      send_request(MODE_SCHED, 8'(i * 17), 32'd2);
    end
    send_request(MODE_SCHED, 8'hAA, 32'd5);
    send_request(MODE_TICK, 8'h00, 32'h0);
    send_request(MODE_TICK, 8'hFF, 32'hFFFF_FFFF);
    send_request(MODE_TICK, 8'h00, 32'h0);
    drain_results();
  endtask

  // Random mix of ticks, schedules, cancels and unused modes; deadlines mostly near the current count.
  task automatic test_random(int count, int idle_pct, int stall_pct);
    int          pick;
    logic [1:0]  mode;
    logic [7:0]  id;
    logic [31:0] dl;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      mode = (pick < 35) ? MODE_TICK : (pick < 75) ? MODE_SCHED :
             (pick < 95) ? MODE_CANCEL : 2'd3;
      id   = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15));
      pick = $urandom_range(9);
      if (pick < 8) dl = mdl_tick + $urandom_range(20);
      else if (pick == 8) dl = $urandom;
      else dl = mdl_tick - $urandom_range(3);
      send_request(mode, id, dl);
    end
    // Hold off new requests until the block has caught up.
    drain_results();
  endtask

  // Receiver stalls at the configured rate.
  always @(posedge clk) begin
    if (rst) res_if.ready <= 1'b0;
    else res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result with the oldest prediction.
  always @(posedge clk) begin
    res_t exp_r;
    if (!rst && res_if.valid && res_if.ready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result id=%0h status=%0d last=%0b", $time,
                 res_if.event_id_res, res_if.status, res_if.last);
        error_count++;
      end else begin
        exp_r = pending_results[0];
        pending_results.delete(0);
        if (exp_r.event_id_res !== res_if.event_id_res) begin
          $display("%0t: event_id_res expected %0h actual %0h", $time,
                   exp_r.event_id_res, res_if.event_id_res);
          error_count++;
        end
        if (exp_r.status !== res_if.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_r.status, res_if.status);
          error_count++;
        end
        if (exp_r.last !== res_if.last) begin
          $display("%0t: last expected %0b actual %0b", $time,
                   exp_r.last, res_if.last);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results owed", $time,
                 pending_results.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    mdl_tick       = 32'd0;
    mdl_used       = 0;
    error_count    = 0;
    request_count  = 0;
    result_count   = 0;
    fired_count    = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst             <= 1'b1;
    req_if.valid    <= 1'b0;
    req_if.mode     <= MODE_TICK;
    req_if.event_id <= 8'h00;
    req_if.deadline <= 32'h0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(89, 0, 0);
    test_random(89, 74, 0);
    test_random(89, 0, 74);
    test_random(89, 17, 17);

    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      error_count++;
    end
    $display("Sent %0d requests and checked %0d results, %0d of them fired events,",
             request_count, result_count, fired_count);
    $display("across free-running, sender-idle, receiver-stall and mixed phases.");
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
